// ===== rtl/pin_entry_lock_controller_core_macros.svh =====
// Assertion macros used by the top module, which carries the checks.
`ifndef PIN_ENTRY_LOCK_CONTROLLER_CORE_MACROS_SVH
`define PIN_ENTRY_LOCK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PELC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PELC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pelc_pkg.sv =====
package pelc_pkg;

    localparam int PIN_MAX   = 8;
    localparam int WIN_IDX_W = $clog2(PIN_MAX);
    localparam int FILL_W    = $clog2(PIN_MAX + 1);
    localparam int KEY_W     = 8;
    localparam int REQ_W     = 2;
    localparam int ACT_W     = 4;
    localparam int CNT_W     = 16;
    localparam int DIV_W     = 8;
    localparam int MS_W      = 24;
    localparam int PLEN_W    = 4;
    localparam int PIN_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Request types
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HOLD    = 2'd2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_MACRO    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_LITERAL  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ACCEPT   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_REJECT   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_LOCKOUT  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_WIPE     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_RESET    = 4'd7;
    localparam logic [ACT_W-1:0] ACT_IDLE_OUT = 4'd8;
    localparam logic [ACT_W-1:0] ACT_LOGOUT   = 4'd9;
    localparam logic [ACT_W-1:0] ACT_MODE_TGL = 4'd10;
    localparam logic [ACT_W-1:0] ACT_TMO_TGL  = 4'd11;

    // Special keys
    localparam logic [KEY_W-1:0] KEY_MODE   = 8'h23;
    localparam logic [KEY_W-1:0] KEY_D      = 8'h44;
    localparam logic [KEY_W-1:0] KEY_LOGOUT = 8'h2A;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_WORD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_EVERY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIPE_EVERY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS  = 3'd6;

    // Configuration reset values
    localparam logic [PLEN_W-1:0] RST_PIN_LENGTH = 4'd5;
    localparam logic [KEY_W-1:0]  RST_END_CHAR   = 8'd42;
    localparam logic [DIV_W-1:0]  RST_LOCK_EVERY = 8'd3;
    localparam logic [DIV_W-1:0]  RST_WIPE_EVERY = 8'd9;
    localparam logic [MS_W-1:0]   RST_IDLE_TMO   = 24'd600000;
    localparam logic [MS_W-1:0]   RST_LOCKOUT_MS = 24'd30000;

    typedef struct packed {
        logic load;        // capture the accepted item
        logic exec;        // apply the item to the state
        logic mod_lock;    // start remainder by lockout_every
        logic mod_wipe;    // start remainder by wipe_every
        logic fail_reject;
        logic fail_lock;
        logic fail_wipe;
        logic out_load;    // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic fail_path;   // item is a wrong PIN entry
        logic lock_zero;
        logic wipe_zero;
        logic mod_done;
        logic mod_zero;
    } t_dp_sts;

endpackage

// ===== rtl/pelc_mod.sv =====
module pelc_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pelc_pkg::CNT_W-1:0] i_dividend,
    input  logic [pelc_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_done,
    output logic                       o_zero
);
    import pelc_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_dvd, n_dvd;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [DIV_W:0]    r_rem, n_rem;
    logic [DIV_W:0]    trial;

    // Restoring division, one dividend bit per cycle; only the remainder is kept.
    always_comb begin
        trial  = {r_rem[DIV_W-1:0], r_dvd[CNT_W-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[CNT_W-2:0], 1'b0};
            n_rem = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(CNT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);

endmodule

// ===== rtl/pelc_dp.sv =====
module pelc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pelc_pkg::REQ_W-1:0]       i_req_type,
    input  logic [pelc_pkg::KEY_W-1:0]       i_key_code,
    input  logic                             i_cfg_we,
    input  logic [pelc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pelc_pkg::PIN_W-1:0]       i_cfg_data,
    input  pelc_pkg::t_dp_cmd                i_cmd,
    output pelc_pkg::t_dp_sts                o_sts,
    output logic [pelc_pkg::OUT_DATA_W-1:0]  o_result
);
    import pelc_pkg::*;

    // Configuration
    logic [PIN_W-1:0]  r_pin_word;
    logic [PLEN_W-1:0] r_pin_len;
    logic [KEY_W-1:0]  r_end_char;
    logic [DIV_W-1:0]  r_lock_every;
    logic [DIV_W-1:0]  r_wipe_every;
    logic [MS_W-1:0]   r_idle_tmo;
    logic [MS_W-1:0]   r_lock_ms;

    // Item
    logic [REQ_W-1:0]  r_req;
    logic [KEY_W-1:0]  r_key;

    // Lock state
    logic [KEY_W-1:0]  r_win [PIN_MAX];
    logic [KEY_W-1:0]  n_win [PIN_MAX];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_unl, n_unl;
    logic              r_lit, n_lit;
    logic              r_skip, n_skip;
    logic              r_tdis, n_tdis;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [MS_W-1:0]   r_idle, n_idle;
    logic [MS_W-1:0]   r_lockt, n_lockt;
    logic [ACT_W-1:0]  r_action, n_action;
    logic [KEY_W-1:0]  r_key_out, n_key_out;
    logic [OUT_DATA_W-1:0] r_result;

    logic [KEY_W-1:0]  sh_win [PIN_MAX];
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] win_n;
    logic [WIN_IDX_W-1:0] idx;
    logic              match;
    logic              compare;
    logic              keys_live;
    logic [MS_W-1:0]   idle_inc;
    logic              clr;
    logic              mod_done;
    logic              mod_zero;

    pelc_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_lock | i_cmd.mod_wipe),
        .i_dividend (r_count),
        .i_divisor  (i_cmd.mod_wipe ? r_wipe_every : r_lock_every),
        .o_done     (mod_done),
        .o_zero     (mod_zero)
    );

    // Window after shifting in the current key, and the PIN compare on it.
    always_comb begin
        sh_win[0] = r_key;
        for (int i = 1; i < PIN_MAX; i++) begin
            sh_win[i] = r_win[i-1];
        end
        if (r_pin_len == '0) begin
            win_n = FILL_W'(1);
        end else if (r_pin_len > PLEN_W'(PIN_MAX)) begin
            win_n = FILL_W'(PIN_MAX);
        end else begin
            win_n = FILL_W'(r_pin_len);
        end
        fill_inc = (r_fill < FILL_W'(PIN_MAX)) ? r_fill + 1'b1 : r_fill;
        compare  = (fill_inc >= win_n) && (r_key == r_end_char);
        match    = 1'b1;
        idx      = '0;
        for (int i = 0; i < PIN_MAX; i++) begin
            if (FILL_W'(i) < win_n) begin
                idx = WIN_IDX_W'(win_n - FILL_W'(1) - FILL_W'(i));
                if (sh_win[idx] != r_pin_word[8*i +: 8]) begin
                    match = 1'b0;
                end
            end
        end
    end

    assign keys_live = (r_lockt == '0);
    assign idle_inc  = (r_idle != '1) ? r_idle + 1'b1 : r_idle;

    always_comb begin
        n_win     = r_win;
        n_fill    = r_fill;
        n_unl     = r_unl;
        n_lit     = r_lit;
        n_skip    = r_skip;
        n_tdis    = r_tdis;
        n_count   = r_count;
        n_idle    = r_idle;
        n_lockt   = r_lockt;
        n_action  = r_action;
        n_key_out = r_key_out;
        clr       = 1'b0;

        if (i_cmd.exec) begin
            n_action  = ACT_NONE;
            n_key_out = '0;
            if (r_req == REQ_TICK) begin
                if (r_lockt != '0) begin
                    n_lockt = r_lockt - 1'b1;
                end
                n_idle = r_tdis ? '0 : idle_inc;
                if (!r_tdis && r_unl && (r_idle_tmo != '0) && (n_idle >= r_idle_tmo)) begin
                    n_unl  = 1'b0;
                    n_fill = '0;
                    for (int i = 0; i < PIN_MAX; i++) begin
                        n_win[i] = '0;
                    end
                    n_action = ACT_IDLE_OUT;
                end
            end else if (r_req == REQ_RELEASE && keys_live) begin
                n_idle = '0;
                if (r_unl) begin
                    if (r_skip) begin
                        n_skip = 1'b0;
                    end else begin
                        n_action  = r_lit ? ACT_LITERAL : ACT_MACRO;
                        n_key_out = r_key;
                    end
                end else begin
                    n_win  = sh_win;
                    n_fill = fill_inc;
                    if (compare && match) begin
                        n_unl    = 1'b1;
                        n_count  = '0;
                        n_action = ACT_ACCEPT;
                    end else if (compare) begin
                        // The action is settled once the multiple checks have run.
                        n_count = (r_count != '1) ? r_count + 1'b1 : r_count;
                    end
                end
            end else if (r_req == REQ_HOLD && keys_live) begin
                if (r_key == KEY_MODE) begin
                    if (r_unl) begin
                        n_lit    = !r_lit;
                        n_skip   = 1'b1;
                        n_action = ACT_MODE_TGL;
                    end
                end else if (r_key == KEY_D) begin
                    if (!r_unl || !r_lit) begin
                        clr      = 1'b1;
                        n_action = ACT_RESET;
                    end else begin
                        n_skip   = 1'b1;
                        n_tdis   = !r_tdis;
                        n_action = ACT_TMO_TGL;
                    end
                end else if (r_key == KEY_LOGOUT) begin
                    n_unl    = 1'b0;
                    n_action = ACT_LOGOUT;
                end
            end
        end else if (i_cmd.fail_reject) begin
            n_action = ACT_REJECT;
        end else if (i_cmd.fail_lock) begin
            n_lockt  = r_lock_ms;
            n_action = ACT_LOCKOUT;
        end else if (i_cmd.fail_wipe) begin
            clr      = 1'b1;
            n_action = ACT_WIPE;
        end

        if (clr) begin
            for (int i = 0; i < PIN_MAX; i++) begin
                n_win[i] = '0;
            end
            n_fill  = '0;
            n_unl   = 1'b0;
            n_lit   = 1'b0;
            n_skip  = 1'b0;
            n_tdis  = 1'b0;
            n_count = '0;
            n_idle  = '0;
            n_lockt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_word   <= '0;
            r_pin_len    <= RST_PIN_LENGTH;
            r_end_char   <= RST_END_CHAR;
            r_lock_every <= RST_LOCK_EVERY;
            r_wipe_every <= RST_WIPE_EVERY;
            r_idle_tmo   <= RST_IDLE_TMO;
            r_lock_ms    <= RST_LOCKOUT_MS;
            for (int i = 0; i < PIN_MAX; i++) begin
                r_win[i] <= '0;
            end
            r_fill    <= '0;
            r_unl     <= 1'b0;
            r_lit     <= 1'b0;
            r_skip    <= 1'b0;
            r_tdis    <= 1'b0;
            r_count   <= '0;
            r_idle    <= '0;
            r_lockt   <= '0;
            r_action  <= ACT_NONE;
            r_key_out <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PIN_WORD:   r_pin_word   <= i_cfg_data;
                    CFG_PIN_LENGTH: r_pin_len    <= i_cfg_data[PLEN_W-1:0];
                    CFG_END_CHAR:   r_end_char   <= i_cfg_data[KEY_W-1:0];
                    CFG_LOCK_EVERY: r_lock_every <= i_cfg_data[DIV_W-1:0];
                    CFG_WIPE_EVERY: r_wipe_every <= i_cfg_data[DIV_W-1:0];
                    CFG_IDLE_TMO:   r_idle_tmo   <= i_cfg_data[MS_W-1:0];
                    CFG_LOCKOUT_MS: r_lock_ms    <= i_cfg_data[MS_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_unl     <= n_unl;
            r_lit     <= n_lit;
            r_skip    <= n_skip;
            r_tdis    <= n_tdis;
            r_count   <= n_count;
            r_idle    <= n_idle;
            r_lockt   <= n_lockt;
            r_action  <= n_action;
            r_key_out <= n_key_out;
        end
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= i_key_code;
        end
        if (i_cmd.out_load) begin
            r_result <= {(r_lockt != '0), r_count, r_tdis, r_lit, r_unl, r_key_out, r_action};
        end
    end

    assign o_sts.fail_path = (r_req == REQ_RELEASE) && keys_live && !r_unl && compare && !match;
    assign o_sts.lock_zero = (r_lock_every == '0);
    assign o_sts.wipe_zero = (r_wipe_every == '0);
    assign o_sts.mod_done  = mod_done;
    assign o_sts.mod_zero  = mod_zero;
    assign o_result        = r_result;

endmodule

// ===== rtl/pelc_ctrl.sv =====
module pelc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output pelc_pkg::t_dp_cmd o_cmd,
    input  pelc_pkg::t_dp_sts i_sts
);
    import pelc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_WAIT_L = 3'd3;
    localparam logic [2:0] S_WAIT_W = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_sts.fail_path) begin
                    n_state = S_FIN;
                end else if (i_sts.lock_zero) begin
                    n_state = S_START;
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                // The raised failure count is now registered.
                if (i_sts.lock_zero) begin
                    o_cmd.fail_reject = 1'b1;
                    n_state           = S_FIN;
                end else begin
                    o_cmd.mod_lock = 1'b1;
                    n_state        = S_WAIT_L;
                end
            end
            S_WAIT_L: begin
                if (i_sts.mod_done) begin
                    if (!i_sts.mod_zero) begin
                        o_cmd.fail_reject = 1'b1;
                        n_state           = S_FIN;
                    end else if (i_sts.wipe_zero) begin
                        o_cmd.fail_lock = 1'b1;
                        n_state         = S_FIN;
                    end else begin
                        o_cmd.mod_wipe = 1'b1;
                        n_state        = S_WAIT_W;
                    end
                end
            end
            S_WAIT_W: begin
                if (i_sts.mod_done) begin
                    o_cmd.fail_wipe = i_sts.mod_zero;
                    o_cmd.fail_lock = !i_sts.mod_zero;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/pin_entry_lock_controller_core.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tuser[1:0] req_type; tdata[7:0] key_code
// m_axis    out        tdata: action, key_out, unlocked, literal_mode, timeout_off,
//                      fail_total, locked_out
// cfg       in         i_cfg_index register number, i_cfg_data value; always ready
//
// A tick, a hold, or a release that is not a wrong PIN entry goes from S_IDLE through
// S_EXEC to S_FIN, where its result is loaded; a new beat is taken only back in S_IDLE.
// A wrong PIN entry runs up to two 16-step remainder passes in the shared divider,
// none when lockout_every is zero, before its result is loaded in S_FIN.
// The output register holds one finished result; while it is stalled the next item is
// still taken and worked, and its result waits in S_FIN until the register frees.
// Synchronous active-low reset restores config defaults and clears control and lock state.
module pin_entry_lock_controller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pelc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] key_code
    input  logic [pelc_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [1:0] req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] action, [11:4] key_out, [12] unlocked, [13] literal_mode,
    // [14] timeout_off, [30:15] fail_total, [31] locked_out
    output logic [pelc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pelc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pelc_pkg::PIN_W-1:0]         i_cfg_data
);
    import pelc_pkg::*;
    `include "pin_entry_lock_controller_core_macros.svh"

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    pelc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pelc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (s_axis_tuser[REQ_W-1:0]),
        .i_key_code  (s_axis_tdata[KEY_W-1:0]),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (m_axis_tdata)
    );

    `PELC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")
    `PELC_ASSERT_IMP(a_no_lockout_unlocked, m_axis_tvalid, !(m_axis_tdata[12] && m_axis_tdata[31]), "unlocked during lockout")
    `PELC_ASSERT_IMP(a_accept_state, m_axis_tvalid && (m_axis_tdata[3:0] == ACT_ACCEPT), m_axis_tdata[12] && (m_axis_tdata[30:15] == '0), "accept without unlock")
    `PELC_ASSERT_IMP(a_wipe_state, m_axis_tvalid && (m_axis_tdata[3:0] == ACT_WIPE), !m_axis_tdata[12] && (m_axis_tdata[30:15] == '0), "wipe left state")

endmodule
